>>> hw/rtl/tlsc_pkg.sv
// Shared types and constants for the three-LFSR byte stream cipher.
// Used by tlsc_seed_regs, tlsc_keygen and three_lfsr_stream_cipher; no dependencies.
package tlsc_pkg;

  // Register widths
  localparam int unsigned LfsrAW = 17;
  localparam int unsigned LfsrBW = 19;
  localparam int unsigned LfsrCW = 23;
  localparam int unsigned ByteW  = 8;

  // Configuration port
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 23;

  localparam logic [CfgIdxW-1:0] CFG_SEED_A = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_SEED_B = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_SEED_C = 2'd2;

  // Feedback tap masks
  localparam logic [LfsrAW-1:0] TAPS_A = 17'h0002D;
  localparam logic [LfsrBW-1:0] TAPS_B = 19'h0332B;
  localparam logic [LfsrCW-1:0] TAPS_C = 23'h000069;

  // Seed values after reset
  localparam logic [LfsrAW-1:0] SEED_A_RST = 17'h03130;
  localparam logic [LfsrBW-1:0] SEED_B_RST = 19'h21999;
  localparam logic [LfsrCW-1:0] SEED_C_RST = 23'h66C6A6;

  // Combining tables, bit n is the entry at index n = {c0, b0, a0}
  localparam logic [7:0] TAB_ONE   = 8'b1110_1000;
  localparam logic [7:0] TAB_TWO   = 8'b1101_0010;
  localparam logic [7:0] TAB_THREE = 8'b1010_1100;

  typedef struct packed {
    logic [LfsrAW-1:0] a;
    logic [LfsrBW-1:0] b;
    logic [LfsrCW-1:0] c;
  } lfsr_t;

  typedef struct packed {
    lfsr_t seed;
    logic  reload;
  } seed_ctl_t;

  typedef struct packed {
    logic [ByteW-1:0] data_byte;
    logic             restart;
  } in_t;

  typedef struct packed {
    logic [ByteW-1:0] result_byte;
    logic [ByteW-1:0] key_byte;
  } out_t;

endpackage

>>> hw/rtl/tlsc_seed_regs.sv
// Seed register file for the three-LFSR stream cipher.
// Decodes configuration writes and flags a reload of all LFSRs; uses tlsc_pkg.
module tlsc_seed_regs import tlsc_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  output seed_ctl_t          ctl_o
);

  lfsr_t seed_q, seed_d;
  logic  hit;

  // Decode the write, keep the seeds masked to their widths
  always_comb begin
    seed_d = seed_q;
    hit    = 1'b0;
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_SEED_A: begin
          seed_d.a = cfg_data_i[LfsrAW-1:0];
          hit      = 1'b1;
        end
        CFG_SEED_B: begin
          seed_d.b = cfg_data_i[LfsrBW-1:0];
          hit      = 1'b1;
        end
        CFG_SEED_C: begin
          seed_d.c = cfg_data_i[LfsrCW-1:0];
          hit      = 1'b1;
        end
        default: hit = 1'b0;
      endcase
    end
  end

  // Hold the seeds
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seed_q <= '{a: SEED_A_RST, b: SEED_B_RST, c: SEED_C_RST};
    end else begin
      seed_q <= seed_d;
    end
  end

  // New seeds go straight to the LFSRs on a valid write
  assign ctl_o.seed   = seed_d;
  assign ctl_o.reload = hit;

endmodule

>>> hw/rtl/tlsc_keygen.sv
// Keystream byte generator: eight LFSR steps unrolled into XOR logic.
// Purely combinational; uses tlsc_pkg for tap masks and combining tables.
module tlsc_keygen import tlsc_pkg::*; (
  input  lfsr_t            lfsr_i,
  output logic [ByteW-1:0] key_o,
  output lfsr_t            lfsr_o
);

  always_comb begin
    lfsr_t            st;
    logic [2:0]       idx;
    logic [ByteW-1:0] key;
    st  = lfsr_i;
    key = '0;
    // Take one keystream bit per step, LSB first, then advance each register
    for (int i = 0; i < ByteW; i++) begin
      idx    = {st.c[0], st.b[0], st.a[0]};
      key[i] = TAB_ONE[idx] ^ TAB_TWO[idx] ^ TAB_THREE[idx];
      st.a   = {^(st.a & TAPS_A), st.a[LfsrAW-1:1]};
      st.b   = {^(st.b & TAPS_B), st.b[LfsrBW-1:1]};
      st.c   = {^(st.c & TAPS_C), st.c[LfsrCW-1:1]};
    end
    key_o  = key;
    lfsr_o = st;
  end

endmodule

>>> hw/rtl/three_lfsr_stream_cipher.sv
// Top level of the three-LFSR byte stream cipher.
// Instantiates tlsc_seed_regs and tlsc_keygen; uses tlsc_pkg.

// One byte is ciphered per clock unless the input stalls: each accepted word runs
// eight LFSR steps through the unrolled XOR network of tlsc_keygen between the
// LFSR state registers and the result register, so a word can be accepted every
// cycle. A two-entry output buffer (result register plus skid register) keeps
// input stall registered; the input stalls only when both entries are full.
// Encryption and decryption are the same operation. Seed writes on the
// configuration port reload all three LFSRs at once and are always ready; a word
// with restart set reloads the LFSRs from the seeds before it is ciphered.
module three_lfsr_stream_cipher import tlsc_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  // input words
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  in_t                 in_data_i,
  // result words
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output out_t                out_data_o,
  // seed configuration
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  seed_ctl_t        seed_ctl;
  lfsr_t            lfsr_q, lfsr_d, kg_in, kg_next;
  logic [ByteW-1:0] kg_key;
  out_t             new_word;
  out_t             out_q, out_d, skid_q, skid_d;
  logic             out_valid_q, out_valid_d, skid_valid_q, skid_valid_d;
  logic             in_fire, out_fire, cfg_fire;

  assign cfg_ready_o = 1'b1;
  assign cfg_fire    = cfg_valid_i & cfg_ready_o;
  assign in_fire     = in_valid_i & ~skid_valid_q;
  assign out_fire    = out_valid_q & ~out_stall_i;

  tlsc_seed_regs u_seed_regs (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_fire),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .ctl_o       (seed_ctl)
  );

  // Restart selects the seeds as the starting state of this word
  assign kg_in = in_data_i.restart ? seed_ctl.seed : lfsr_q;

  tlsc_keygen u_keygen (
    .lfsr_i (kg_in),
    .key_o  (kg_key),
    .lfsr_o (kg_next)
  );

  assign new_word.result_byte = in_data_i.data_byte ^ kg_key;
  assign new_word.key_byte    = kg_key;

  // Advance the LFSRs on an accepted word, reload on a seed write
  always_comb begin
    lfsr_d = lfsr_q;
    if (seed_ctl.reload) begin
      lfsr_d = seed_ctl.seed;
    end else if (in_fire) begin
      lfsr_d = kg_next;
    end
  end

  // Output register with skid entry
  always_comb begin
    out_d        = out_q;
    skid_d       = skid_q;
    out_valid_d  = out_valid_q;
    skid_valid_d = skid_valid_q;
    if (!out_valid_q || out_fire) begin
      out_valid_d  = skid_valid_q | in_fire;
      out_d        = skid_valid_q ? skid_q : new_word;
      skid_valid_d = 1'b0;
    end else if (in_fire) begin
      skid_d       = new_word;
      skid_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lfsr_q       <= '{a: SEED_A_RST, b: SEED_B_RST, c: SEED_C_RST};
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      lfsr_q       <= lfsr_d;
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  // Payload registers need no reset
  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  assign in_stall_o  = skid_valid_q;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

`ifndef NO_ASSERTIONS
  // The skid entry is only filled behind a waiting result
  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid entry valid without a result word");

  // A seed write leaves the LFSRs equal to the stored seeds
  a_cfg_reload: assert property (@(posedge clk_i) disable iff (!rst_ni)
    seed_ctl.reload |=> (lfsr_q == $past(seed_ctl.seed)))
    else $error("LFSRs not reloaded after seed write");

  // State moves only on an accepted word or a seed write
  a_lfsr_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!in_fire && !seed_ctl.reload) |=> $stable(lfsr_q))
    else $error("LFSR state changed without a word or seed write");

  // A word accepted into a free output stage shows its key next cycle
  a_direct_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && (!out_valid_q || out_fire))
      |=> (out_valid_q && out_q.key_byte == $past(kg_key)))
    else $error("accepted word did not reach the result register");
`endif

endmodule

>>> verif/tlsc_cipher_checker.sv
// Checker for the three-LFSR byte stream cipher: watches the input, result and seed channels.
// Keeps its own copy of the seeds and LFSRs, predicts each result word and compares it.
// Depends on tlsc_pkg for the word types, widths, tap masks and seed reset values.
`timescale 1ns / 100ps

module tlsc_cipher_checker import tlsc_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                in_stall_i,
  input  in_t                 in_data_i,
  input  logic                out_valid_i,
  input  logic                out_stall_i,
  input  out_t                out_data_i,
  input  logic                cfg_valid_i,
  input  logic                cfg_ready_i,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  output int unsigned         mismatch_count_o,
  output int unsigned         pending_o
);

  // Keep the report readable when the block is badly broken
  localparam int unsigned MaxReports = 200;

  lfsr_t       seeds;
  lfsr_t       lfsrs;
  out_t        expected_words[$];
  int unsigned mismatches;

  initial begin
    mismatch_count_o = 0;
    pending_o        = 0;
  end

  always @(posedge clk_i or negedge rst_ni) begin
    out_t             got;
    out_t             want;
    logic [ByteW-1:0] key;
    if (!rst_ni) begin
      seeds = {SEED_A_RST, SEED_B_RST, SEED_C_RST};
      lfsrs = seeds;
      expected_words.delete();
      mismatches = 0;
    end else begin
      // Compare the result word with the oldest expected word
      if (out_valid_i && !out_stall_i) begin
        got = out_data_i;
        if (expected_words.size() == 0) begin
          mismatches++;
          if (mismatches <= MaxReports)
            $display("%0t: result word with none expected, got result %02h key %02h",
                     $time, got.result_byte, got.key_byte);
        end else begin
          want = expected_words.pop_front();
          if (got.result_byte !== want.result_byte) begin
            mismatches++;
            if (mismatches <= MaxReports)
              $display("%0t: result_byte expected %02h, got %02h",
                       $time, want.result_byte, got.result_byte);
          end
          if (got.key_byte !== want.key_byte) begin
            mismatches++;
            if (mismatches <= MaxReports)
              $display("%0t: key_byte expected %02h, got %02h",
                       $time, want.key_byte, got.key_byte);
          end
        end
      end

      // Store a seed masked to its width and reload all three registers; drop other indexes
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          CFG_SEED_A: begin
            seeds.a = cfg_data_i[LfsrAW-1:0];
            lfsrs   = seeds;
          end
          CFG_SEED_B: begin
            seeds.b = cfg_data_i[LfsrBW-1:0];
            lfsrs   = seeds;
          end
          CFG_SEED_C: begin
            seeds.c = cfg_data_i[LfsrCW-1:0];
            lfsrs   = seeds;
          end
          default: ;
        endcase
      end

      // Predict the word: eight keystream bits LSB first, each followed by one shift
      if (in_valid_i && !in_stall_i) begin
        if (in_data_i.restart)
          lfsrs = seeds;
        key = '0;
        for (int i = 0; i < ByteW; i++) begin
          key[i]  = lfsrs.a[0] ^ lfsrs.b[0] ^ lfsrs.c[0];
          lfsrs.a = {^(lfsrs.a & TAPS_A), lfsrs.a[LfsrAW-1:1]};
          lfsrs.b = {^(lfsrs.b & TAPS_B), lfsrs.b[LfsrBW-1:1]};
          lfsrs.c = {^(lfsrs.c & TAPS_C), lfsrs.c[LfsrCW-1:1]};
        end
        want.result_byte = in_data_i.data_byte ^ key;
        want.key_byte    = key;
        expected_words.push_back(want);
      end
    end
    mismatch_count_o <= mismatches;
    pending_o        <= expected_words.size();
  end

endmodule

>>> verif/three_lfsr_stream_cipher_tb.sv
// Top of the testbench for the three-LFSR byte stream cipher: clock, reset, stimulus, verdict.
// Instantiates three_lfsr_stream_cipher and tlsc_cipher_checker; uses tlsc_pkg.
`timescale 1ns / 100ps

module three_lfsr_stream_cipher_tb;
  import tlsc_pkg::*;

  // Index past the last seed register, must be ignored by the block
  localparam logic [CfgIdxW-1:0] CFG_UNUSED = 2'd3;

  localparam int unsigned RandomPhases  = 7;
  localparam int unsigned WordsPerPhase = 230;
  localparam int unsigned CalmPhase     = 3;
  localparam int unsigned CycleLimit    = 200000;

  logic                clk;
  logic                rst_n;
  logic                in_valid;
  logic                in_stall;
  in_t                 in_data;
  logic                out_valid;
  logic                out_stall;
  out_t                out_data;
  logic                cfg_valid;
  logic                cfg_ready;
  logic [CfgIdxW-1:0]  cfg_index;
  logic [CfgDataW-1:0] cfg_data;
  int unsigned         mismatch_count;
  int unsigned         pending;
  logic                calm;
  int unsigned         cycle_count;

  three_lfsr_stream_cipher DUT (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  tlsc_cipher_checker u_checker (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .in_valid_i       (in_valid),
    .in_stall_i       (in_stall),
    .in_data_i        (in_data),
    .out_valid_i      (out_valid),
    .out_stall_i      (out_stall),
    .out_data_i       (out_data),
    .cfg_valid_i      (cfg_valid),
    .cfg_ready_i      (cfg_ready),
    .cfg_index_i      (cfg_index),
    .cfg_data_i       (cfg_data),
    .mismatch_count_o (mismatch_count),
    .pending_o        (pending)
  );

  // 2 ns clock
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Stall the result side at random, except during the calm stretch
  always @(posedge clk) begin
    out_stall <= !calm && ($urandom_range(99) < 29);
  end

  // Give up on a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("** three_lfsr_stream_cipher: FAILED **");
      $finish;
    end
  end

  // Present one word, with random idle cycles ahead of it, and hold it until accepted
  task automatic send_word(input logic [ByteW-1:0] data, input logic restart);
    while (!calm && $urandom_range(99) < 29) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid          <= 1'b1;
    in_data.data_byte <= data;
    in_data.restart   <= restart;
    do @(posedge clk); while (in_stall);
  endtask

  // Drop valid and wait until every expected word has come out
  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  // Write one register and hold until the port takes it
  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
  endtask

  // Write the selected registers in order A, B, C, unused index; then drop valid
  task automatic write_seeds(input logic [3:0] which, input logic [CfgDataW-1:0] a,
                             input logic [CfgDataW-1:0] b, input logic [CfgDataW-1:0] c);
    if (which[0]) write_reg(CFG_SEED_A, a);
    if (which[1]) write_reg(CFG_SEED_B, b);
    if (which[2]) write_reg(CFG_SEED_C, c);
    if (which[3]) write_reg(CFG_UNUSED, CfgDataW'($urandom));
    cfg_valid <= 1'b0;
  endtask

  // Pick a seed: mostly random over the full port width, sometimes all zeros or all ones
  function automatic logic [CfgDataW-1:0] seed_value();
    case ($urandom_range(7))
      0:       return '0;
      1:       return '1;
      default: return CfgDataW'($urandom);
    endcase
  endfunction

  initial begin
    clk         = 1'b0;
    rst_n       = 1'b0;
    in_valid    = 1'b0;
    in_data     = '0;
    out_stall   = 1'b0;
    cfg_valid   = 1'b0;
    cfg_index   = CFG_SEED_A;
    cfg_data    = '0;
    calm        = 1'b0;
    cycle_count = 0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // Reset seeds: data extremes, single bits, restart on and off
    send_word(8'h00, 1'b0);
    send_word(8'hFF, 1'b0);
    send_word(8'h55, 1'b0);
    send_word(8'hAA, 1'b0);
    send_word(8'h01, 1'b1);
    send_word(8'h80, 1'b1);
    send_word(8'hFF, 1'b1);
    send_word(8'h7F, 1'b0);
    send_word(8'hFE, 1'b0);
    send_word(ByteW'($urandom), 1'b0);

    // Write to the unused index: the stream must carry on without a reload
    wait_drained();
    write_seeds(4'b1000, '0, '0, '0);
    send_word(ByteW'($urandom), 1'b0);
    send_word(ByteW'($urandom), 1'b0);
    send_word(ByteW'($urandom), 1'b0);

    // All-ones seeds, written over the full port width to exercise the masking
    wait_drained();
    write_seeds(4'b0111, '1, '1, '1);
    send_word(8'h00, 1'b0);
    send_word(8'hFF, 1'b0);
    send_word(8'h3C, 1'b1);
    send_word(8'hC3, 1'b0);

    // All-zero seeds: keystream stays zero
    wait_drained();
    write_seeds(4'b0111, '0, '0, '0);
    send_word(8'hFF, 1'b0);
    send_word(8'h5A, 1'b1);
    send_word(8'h00, 1'b0);

    // One register zero, the others at their maximum
    wait_drained();
    write_seeds(4'b0110, '0, '1, '1);
    send_word(ByteW'($urandom), 1'b0);
    send_word(ByteW'($urandom), 1'b0);
    send_word(ByteW'($urandom), 1'b1);

    // Random phases with fresh seeds; one phase runs with no idling on either side
    for (int p = 0; p < RandomPhases; p++) begin
      logic [3:0] which;
      wait_drained();
      which = (p == 0) ? 4'b0111 : 4'($urandom);
      write_seeds(which, seed_value(), seed_value(), seed_value());
      calm = (p == CalmPhase);
      for (int n = 0; n < WordsPerPhase; n++)
        send_word(ByteW'($urandom), $urandom_range(15) == 0);
      calm = 1'b0;
    end

    wait_drained();
    repeat (8) @(posedge clk);
    if (mismatch_count == 0 && pending == 0) begin
      $display("** three_lfsr_stream_cipher: PASSED **");
    end else begin
      $display("** three_lfsr_stream_cipher: FAILED **");
    end
    $finish;
  end

endmodule
